@@ src/rpe_pkg.sv @@
// shared types, constants and fixed-point helpers of the reprojection error unit
`default_nettype none

package rpe_pkg;

  localparam int MAX_CAMERAS_DEF = 64;
  localparam int MAX_POINTS_DEF  = 1024;

  localparam int CAM_WORDS = 10;
  localparam int PT_WORDS  = 3;

  localparam int Q_W    = 32;
  localparam int PROD_W = 48;
  localparam int SUM_W  = 52;

  localparam int ACT_W      = 2;
  localparam int CAM_IDX_W  = 6;
  localparam int PT_IDX_W   = 10;
  localparam int WSEL_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 64;

  // digit-by-digit square root of a 34-bit radicand
  localparam int SQRT_STEPS = 17;
  localparam int ROOT_W     = 17;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int SQ_REM_W   = ROOT_W + 3;

  // restoring divide of a 48-bit magnitude by a 32-bit magnitude
  localparam int DIV_STEPS = 48;
  localparam int DEN_W     = 32;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef q_t [CAM_WORDS-1:0]       cam_row_t;
  typedef q_t [PT_WORDS-1:0]        pt_row_t;

  typedef struct packed {
    logic                last;
    logic [STATUS_W-1:0] status;
    q_t                  meas_x;
    q_t                  meas_y;
  } ctx_t;

  localparam logic [ACT_W-1:0] ACT_LOAD_CAM = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_PT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PROJECT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEG_ROOT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEPTH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW   = 3'd4;

  localparam q_t   Q_MAX   = 32'sh7FFF_FFFF;
  localparam q_t   Q_MIN   = 32'sh8000_0000;
  localparam q_t   ONE_Q   = 32'sh0001_0000;
  localparam sum_t SUM_MAX = sum_t'(Q_MAX);
  localparam sum_t SUM_MIN = sum_t'(Q_MIN);

  // q16.16 product, rounded half up
  function automatic prod_t mq(input q_t a, input q_t b);
    logic signed [2*Q_W-1:0] p;
    p = a * b;
    p = p + 64'sd32768;
    return p[2*Q_W-1:16];
  endfunction

  function automatic q_t sat32(input sum_t v);
    q_t r;
    if (v > SUM_MAX) begin
      r = Q_MAX;
    end else if (v < SUM_MIN) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/rpe_div.sv @@
// pipelined two-lane signed divider: (num << 16) / den, truncated and saturated
`default_nettype none

module rpe_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpe_pkg::q_t   num_x_i,
  input  rpe_pkg::q_t   num_y_i,
  input  rpe_pkg::q_t   den_i,
  input  rpe_pkg::ctx_t ctx_i,
  output logic          valid_o,
  output rpe_pkg::q_t   quo_x_o,
  output rpe_pkg::q_t   quo_y_o,
  output rpe_pkg::ctx_t ctx_o
);

  localparam int N  = rpe_pkg::DIV_STEPS;
  localparam int DW = rpe_pkg::DEN_W;

  logic                vld_q [0:N];
  logic [DW-1:0]       den_q [0:N];
  logic [N-1:0]        dvd_q [0:N][2];
  logic [N-1:0]        quo_q [0:N][2];
  logic [DW-1:0]       rem_q [0:N][2];
  logic                neg_q [0:N][2];
  rpe_pkg::ctx_t       ctx_q [0:N];

  logic [DW-1:0]       num_mag [2];
  logic [DW-1:0]       den_mag;
  logic [DW:0]         sh      [1:N][2];
  logic [DW-1:0]       rem_d   [1:N][2];
  logic [N-1:0]        quo_d   [1:N][2];
  logic signed [N:0]   qs      [2];

  logic                out_vld_q;
  rpe_pkg::q_t         out_q   [2];
  rpe_pkg::ctx_t       out_ctx_q;

  always_comb begin
    num_mag[0] = num_x_i[DW-1] ? DW'(-num_x_i) : DW'(num_x_i);
    num_mag[1] = num_y_i[DW-1] ? DW'(-num_y_i) : DW'(num_y_i);
    den_mag    = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    for (int k = 1; k <= N; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh[k][l]    = {rem_q[k-1][l], dvd_q[k-1][l][N-k]};
        quo_d[k][l] = quo_q[k-1][l];
        if (sh[k][l] >= {1'b0, den_q[k-1]}) begin
          rem_d[k][l]        = DW'(sh[k][l] - {1'b0, den_q[k-1]});
          quo_d[k][l][N-k]   = 1'b1;
        end else begin
          rem_d[k][l] = sh[k][l][DW-1:0];
        end
      end
    end
    for (int l = 0; l < 2; l++) begin
      qs[l] = $signed({1'b0, quo_q[N][l]});
      if (neg_q[N][l]) begin
        qs[l] = -qs[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= N; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= N; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]    <= den_mag;
      ctx_q[0]    <= ctx_i;
      neg_q[0][0] <= num_x_i[DW-1] ^ den_i[DW-1];
      neg_q[0][1] <= num_y_i[DW-1] ^ den_i[DW-1];
      for (int l = 0; l < 2; l++) begin
        dvd_q[0][l] <= {num_mag[l], {(N-DW){1'b0}}};
        quo_q[0][l] <= '0;
        rem_q[0][l] <= '0;
      end
      for (int k = 1; k <= N; k++) begin
        den_q[k] <= den_q[k-1];
        ctx_q[k] <= ctx_q[k-1];
        for (int l = 0; l < 2; l++) begin
          dvd_q[k][l] <= dvd_q[k-1][l];
          quo_q[k][l] <= quo_d[k][l];
          rem_q[k][l] <= rem_d[k][l];
          neg_q[k][l] <= neg_q[k-1][l];
        end
      end
      for (int l = 0; l < 2; l++) begin
        out_q[l] <= rpe_pkg::sat32(rpe_pkg::sum_t'(qs[l]));
      end
      out_ctx_q <= ctx_q[N];
    end
  end

  assign valid_o = out_vld_q;
  assign quo_x_o = out_q[0];
  assign quo_y_o = out_q[1];
  assign ctx_o   = out_ctx_q;

endmodule

`default_nettype wire

@@ src/reprojection_error_unit.sv @@
// top level of the reprojection error unit: tables, projection pipeline, stream ports
`default_nettype none

// Reprojection error unit. Load words (tuser 0 camera, 1 point) write one 32-bit Q16.16
// word into the camera table (10 words per camera) or the point table (3 words per point);
// they produce no output word. A project word (tuser 2) reads one camera row and one point
// row, rebuilds the rotation quaternion, rotates, translates and projects the point and
// returns measured minus projected pixel with a status in tuser (0 ok, 1 negative root
// argument clamped, 2 zero depth saturated) and tlast echoed. One word is accepted every
// cycle while the output register is empty or being taken; a project word passes the
// 17-step square root and the 48-step divider, one step per pipeline stage. Both
// tables are single-write, single-read row memories, so a project word sees every load
// accepted before it. Table entries read before they are written return undefined data.
// The user must write intrinsics over the cfg port only while the unit is idle; the unit
// does not enforce this itself. An index above 4 is ignored.
module reprojection_error_unit #(
  parameter int MAX_CAMERAS = rpe_pkg::MAX_CAMERAS_DEF,
  parameter int MAX_POINTS  = rpe_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input word stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // camera_index, point_index, word_select, load_value, measured_x, measured_y, zero pad
  input  logic [rpe_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic [rpe_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input  logic                               s_axis_tlast_i,
  // result word stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // error_x, error_y
  output logic [rpe_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status
  output logic [rpe_pkg::STATUS_W-1:0]       m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  // intrinsics write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rpe_pkg::Q_W-1:0]            cfg_data_i
);

  localparam int CamAw = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int PtAw  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int S     = rpe_pkg::SQRT_STEPS;
  localparam int RW    = rpe_pkg::ROOT_W;
  localparam int SRW   = rpe_pkg::SQ_REM_W;

  // ---------------------------------------------------------------------------
  // input unpacking and flow control: the whole pipeline advances together
  // ---------------------------------------------------------------------------
  logic [rpe_pkg::CAM_IDX_W-1:0] in_cam_idx;
  logic [rpe_pkg::PT_IDX_W-1:0]  in_pt_idx;
  logic [rpe_pkg::WSEL_W-1:0]    in_wsel;
  rpe_pkg::q_t                   in_load;
  rpe_pkg::ctx_t                 in_ctx;
  logic                          en;
  logic                          accept;
  logic                          in_project;

  assign in_cam_idx = s_axis_tdata_i[5:0];
  assign in_pt_idx  = s_axis_tdata_i[15:6];
  assign in_wsel    = s_axis_tdata_i[19:16];
  assign in_load    = s_axis_tdata_i[51:20];

  always_comb begin
    in_ctx.last   = s_axis_tlast_i;
    in_ctx.status = rpe_pkg::ST_OK;
    in_ctx.meas_x = s_axis_tdata_i[83:52];
    in_ctx.meas_y = s_axis_tdata_i[115:84];
  end

  logic out_vld_q;

  // output register frees up when empty or being taken
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign in_project      = accept && (s_axis_tuser_i == rpe_pkg::ACT_PROJECT);

  // ---------------------------------------------------------------------------
  // intrinsics
  // ---------------------------------------------------------------------------
  rpe_pkg::q_t focal_q, prin_x_q, prin_y_q, aspect_q, skew_q, fa_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= rpe_pkg::ONE_Q;
      prin_x_q <= '0;
      prin_y_q <= '0;
      aspect_q <= rpe_pkg::ONE_Q;
      skew_q   <= '0;
      fa_q     <= rpe_pkg::ONE_Q;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rpe_pkg::CFG_FOCAL:  focal_q  <= cfg_data_i;
          rpe_pkg::CFG_PRIN_X: prin_x_q <= cfg_data_i;
          rpe_pkg::CFG_PRIN_Y: prin_y_q <= cfg_data_i;
          rpe_pkg::CFG_ASPECT: aspect_q <= cfg_data_i;
          rpe_pkg::CFG_SKEW:   skew_q   <= cfg_data_i;
          default: ;
        endcase
      end
      // focal length times aspect ratio, registered, so it follows the registers in the next cycle
      fa_q <= rpe_pkg::sat32(rpe_pkg::sum_t'(rpe_pkg::mq(focal_q, aspect_q)));
    end
  end

  // ---------------------------------------------------------------------------
  // camera and point tables: one row per entry, word-wide writes, registered row reads
  // ---------------------------------------------------------------------------
  rpe_pkg::cam_row_t cam_mem [MAX_CAMERAS];
  rpe_pkg::pt_row_t  pt_mem  [MAX_POINTS];

  logic [CamAw-1:0] cam_addr;
  logic [PtAw-1:0]  pt_addr;
  logic             cam_in_range, pt_in_range, cam_wr, pt_wr;

  assign cam_addr     = CamAw'(in_cam_idx);
  assign pt_addr      = PtAw'(in_pt_idx);
  assign cam_in_range = 32'(in_cam_idx) < MAX_CAMERAS;
  assign pt_in_range  = 32'(in_pt_idx) < MAX_POINTS;
  assign cam_wr = accept && (s_axis_tuser_i == rpe_pkg::ACT_LOAD_CAM) && cam_in_range
                  && (32'(in_wsel) < rpe_pkg::CAM_WORDS);
  assign pt_wr  = accept && (s_axis_tuser_i == rpe_pkg::ACT_LOAD_PT) && pt_in_range
                  && (32'(in_wsel) < rpe_pkg::PT_WORDS);

  // stage a: table read
  logic              a_vld_q;
  rpe_pkg::cam_row_t a_cam_q;
  rpe_pkg::pt_row_t  a_pt_q;
  logic              a_cam_oor_q, a_pt_oor_q;
  rpe_pkg::ctx_t     a_ctx_q;

  always_ff @(posedge clk_i) begin
    if (cam_wr) begin
      cam_mem[cam_addr][in_wsel] <= in_load;
    end
    if (pt_wr) begin
      pt_mem[pt_addr][in_wsel[1:0]] <= in_load;
    end
    if (en) begin
      a_cam_q <= cam_mem[cam_addr];
      a_pt_q  <= pt_mem[pt_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: out-of-range entries read as zero, squares of the rotation vector
  // ---------------------------------------------------------------------------
  rpe_pkg::cam_row_t cm;
  rpe_pkg::pt_row_t  pm;
  logic              b_vld_q;
  rpe_pkg::cam_row_t b_c_q;
  rpe_pkg::pt_row_t  b_m_q;
  rpe_pkg::prod_t    b_sq_q [3];
  rpe_pkg::ctx_t     b_ctx_q;

  assign cm = a_cam_oor_q ? '0 : a_cam_q;
  assign pm = a_pt_oor_q ? '0 : a_pt_q;

  // ---------------------------------------------------------------------------
  // root argument (index 0) and square root steps (1..S), one result bit per stage
  // ---------------------------------------------------------------------------
  rpe_pkg::sum_t     arg_d;
  logic              arg_neg;
  rpe_pkg::ctx_t     arg_ctx;

  logic              sq_vld_q  [0:S];
  logic [rpe_pkg::RAD_W-1:0] sq_rad_q [0:S];
  logic [SRW-1:0]    sq_rem_q  [0:S];
  logic [RW-1:0]     sq_root_q [0:S];
  rpe_pkg::cam_row_t sq_c_q    [0:S];
  rpe_pkg::pt_row_t  sq_m_q    [0:S];
  rpe_pkg::ctx_t     sq_ctx_q  [0:S];

  logic [SRW-1:0]    sq_sh     [1:S];
  logic [SRW-1:0]    sq_trial  [1:S];
  logic [SRW-1:0]    sq_rem_d  [1:S];
  logic [RW-1:0]     sq_root_d [1:S];

  always_comb begin
    arg_d = rpe_pkg::sum_t'(rpe_pkg::ONE_Q) - rpe_pkg::sum_t'(b_sq_q[0])
            - rpe_pkg::sum_t'(b_sq_q[1]) - rpe_pkg::sum_t'(b_sq_q[2]);
    arg_neg = arg_d[rpe_pkg::SUM_W-1];
    arg_ctx = b_ctx_q;
    if (arg_neg) begin
      arg_ctx.status = rpe_pkg::ST_NEG_ROOT;
    end
    for (int k = 1; k <= S; k++) begin
      sq_sh[k]    = {sq_rem_q[k-1][SRW-3:0], sq_rad_q[k-1][2*(S-k) +: 2]};
      sq_trial[k] = {{(SRW-RW-2){1'b0}}, sq_root_q[k-1], 2'b01};
      if (sq_sh[k] >= sq_trial[k]) begin
        sq_rem_d[k]  = sq_sh[k] - sq_trial[k];
        sq_root_d[k] = {sq_root_q[k-1][RW-2:0], 1'b1};
      end else begin
        sq_rem_d[k]  = sq_sh[k];
        sq_root_d[k] = {sq_root_q[k-1][RW-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // quaternion product: h1 products, h2 sums
  // ---------------------------------------------------------------------------
  rpe_pkg::q_t      ha [4];
  rpe_pkg::q_t      hb [4];
  logic             h1_vld_q;
  rpe_pkg::prod_t   h1_p_q [4][4];
  rpe_pkg::pt_row_t h1_t_q;
  rpe_pkg::pt_row_t h1_m_q;
  rpe_pkg::ctx_t    h1_ctx_q;

  logic             h2_vld_q;
  rpe_pkg::q_t      h2_q_q [4];
  rpe_pkg::pt_row_t h2_t_q;
  rpe_pkg::pt_row_t h2_m_q;
  rpe_pkg::ctx_t    h2_ctx_q;
  rpe_pkg::q_t      hq_d [4];

  always_comb begin
    ha[0] = rpe_pkg::q_t'(sq_root_q[S]);
    for (int i = 1; i < 4; i++) begin
      ha[i] = sq_c_q[S][3+i];
    end
    for (int j = 0; j < 4; j++) begin
      hb[j] = sq_c_q[S][j];
    end
    hq_d[0] = rpe_pkg::sat32(rpe_pkg::sum_t'(h1_p_q[0][0]) - rpe_pkg::sum_t'(h1_p_q[1][1])
                           - rpe_pkg::sum_t'(h1_p_q[2][2]) - rpe_pkg::sum_t'(h1_p_q[3][3]));
    hq_d[1] = rpe_pkg::sat32(rpe_pkg::sum_t'(h1_p_q[0][1]) + rpe_pkg::sum_t'(h1_p_q[1][0])
                           + rpe_pkg::sum_t'(h1_p_q[2][3]) - rpe_pkg::sum_t'(h1_p_q[3][2]));
    hq_d[2] = rpe_pkg::sat32(rpe_pkg::sum_t'(h1_p_q[0][2]) - rpe_pkg::sum_t'(h1_p_q[1][3])
                           + rpe_pkg::sum_t'(h1_p_q[2][0]) + rpe_pkg::sum_t'(h1_p_q[3][1]));
    hq_d[3] = rpe_pkg::sat32(rpe_pkg::sum_t'(h1_p_q[0][3]) + rpe_pkg::sum_t'(h1_p_q[1][2])
                           - rpe_pkg::sum_t'(h1_p_q[2][1]) + rpe_pkg::sum_t'(h1_p_q[3][0]));
  end

  // ---------------------------------------------------------------------------
  // rotation: r1/r2 form q * point, r3/r4 multiply by the conjugate and translate
  // ---------------------------------------------------------------------------
  logic             r1_vld_q;
  rpe_pkg::prod_t   r1_p_q [4][3];
  rpe_pkg::q_t      r1_q_q [4];
  rpe_pkg::pt_row_t r1_t_q;
  rpe_pkg::ctx_t    r1_ctx_q;

  logic             r2_vld_q;
  rpe_pkg::q_t      r2_v_q [4];   // s, xr, yr, zr
  rpe_pkg::q_t      r2_q_q [4];
  rpe_pkg::pt_row_t r2_t_q;
  rpe_pkg::ctx_t    r2_ctx_q;
  rpe_pkg::q_t      rv_d [4];

  logic             r3_vld_q;
  rpe_pkg::prod_t   r3_p_q [3][4];
  rpe_pkg::pt_row_t r3_t_q;
  rpe_pkg::ctx_t    r3_ctx_q;
  rpe_pkg::q_t      r3_a [3][4];
  rpe_pkg::q_t      r3_b [3][4];

  logic             r4_vld_q;
  rpe_pkg::q_t      r4_x_q, r4_y_q, r4_z_q;
  rpe_pkg::ctx_t    r4_ctx_q;
  rpe_pkg::q_t      xyz_d [3];

  always_comb begin
    rv_d[0] = rpe_pkg::sat32(-rpe_pkg::sum_t'(r1_p_q[1][0]) - rpe_pkg::sum_t'(r1_p_q[2][1])
                           - rpe_pkg::sum_t'(r1_p_q[3][2]));
    rv_d[1] = rpe_pkg::sat32(rpe_pkg::sum_t'(r1_p_q[0][0]) + rpe_pkg::sum_t'(r1_p_q[2][2])
                           - rpe_pkg::sum_t'(r1_p_q[3][1]));
    rv_d[2] = rpe_pkg::sat32(rpe_pkg::sum_t'(r1_p_q[0][1]) + rpe_pkg::sum_t'(r1_p_q[3][0])
                           - rpe_pkg::sum_t'(r1_p_q[1][2]));
    rv_d[3] = rpe_pkg::sat32(rpe_pkg::sum_t'(r1_p_q[0][2]) + rpe_pkg::sum_t'(r1_p_q[1][1])
                           - rpe_pkg::sum_t'(r1_p_q[2][0]));

    // per output row: (q, s) (q0, own) (q, next) (q, other), signs - + - +
    r3_a[0][0] = r2_q_q[1]; r3_b[0][0] = r2_v_q[0];
    r3_a[0][1] = r2_q_q[0]; r3_b[0][1] = r2_v_q[1];
    r3_a[0][2] = r2_q_q[3]; r3_b[0][2] = r2_v_q[2];
    r3_a[0][3] = r2_q_q[2]; r3_b[0][3] = r2_v_q[3];
    r3_a[1][0] = r2_q_q[2]; r3_b[1][0] = r2_v_q[0];
    r3_a[1][1] = r2_q_q[0]; r3_b[1][1] = r2_v_q[2];
    r3_a[1][2] = r2_q_q[1]; r3_b[1][2] = r2_v_q[3];
    r3_a[1][3] = r2_q_q[3]; r3_b[1][3] = r2_v_q[1];
    r3_a[2][0] = r2_q_q[3]; r3_b[2][0] = r2_v_q[0];
    r3_a[2][1] = r2_q_q[0]; r3_b[2][1] = r2_v_q[3];
    r3_a[2][2] = r2_q_q[2]; r3_b[2][2] = r2_v_q[1];
    r3_a[2][3] = r2_q_q[1]; r3_b[2][3] = r2_v_q[2];

    for (int r = 0; r < 3; r++) begin
      xyz_d[r] = rpe_pkg::sat32(-rpe_pkg::sum_t'(r3_p_q[r][0]) + rpe_pkg::sum_t'(r3_p_q[r][1])
                              - rpe_pkg::sum_t'(r3_p_q[r][2]) + rpe_pkg::sum_t'(r3_p_q[r][3])
                              + rpe_pkg::sum_t'(r3_t_q[r]));
    end
  end

  // ---------------------------------------------------------------------------
  // projection numerators: p1 products, p2 sums
  // ---------------------------------------------------------------------------
  logic           p1_vld_q;
  rpe_pkg::prod_t p1_fx_q, p1_sy_q, p1_pxz_q, p1_fay_q, p1_pyz_q;
  rpe_pkg::q_t    p1_z_q;
  rpe_pkg::ctx_t  p1_ctx_q;
  rpe_pkg::ctx_t  p1_ctx_d;

  logic           p2_vld_q;
  rpe_pkg::q_t    p2_nx_q, p2_ny_q, p2_z_q;
  rpe_pkg::ctx_t  p2_ctx_q;

  always_comb begin
    p1_ctx_d = r4_ctx_q;
    // zero depth wins over a clamped root
    if (r4_z_q == '0) begin
      p1_ctx_d.status = rpe_pkg::ST_ZERO_DEPTH;
    end
  end

  // ---------------------------------------------------------------------------
  // valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      for (int k = 0; k <= S; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
      h1_vld_q <= 1'b0;
      h2_vld_q <= 1'b0;
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q     <= in_project;
      b_vld_q     <= a_vld_q;
      sq_vld_q[0] <= b_vld_q;
      for (int k = 1; k <= S; k++) begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
      h1_vld_q <= sq_vld_q[S];
      h2_vld_q <= h1_vld_q;
      r1_vld_q <= h2_vld_q;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      p1_vld_q <= r4_vld_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cam_oor_q <= !cam_in_range;
      a_pt_oor_q  <= !pt_in_range;
      a_ctx_q     <= in_ctx;

      b_c_q   <= cm;
      b_m_q   <= pm;
      b_ctx_q <= a_ctx_q;
      for (int k = 0; k < 3; k++) begin
        b_sq_q[k] <= rpe_pkg::mq(cm[4+k], cm[4+k]);
      end

      sq_rad_q[0]  <= arg_neg ? '0 : {1'b0, arg_d[RW-1:0], 16'h0000};
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_c_q[0]    <= b_c_q;
      sq_m_q[0]    <= b_m_q;
      sq_ctx_q[0]  <= arg_ctx;
      for (int k = 1; k <= S; k++) begin
        sq_rad_q[k]  <= sq_rad_q[k-1];
        sq_rem_q[k]  <= sq_rem_d[k];
        sq_root_q[k] <= sq_root_d[k];
        sq_c_q[k]    <= sq_c_q[k-1];
        sq_m_q[k]    <= sq_m_q[k-1];
        sq_ctx_q[k]  <= sq_ctx_q[k-1];
      end

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          h1_p_q[i][j] <= rpe_pkg::mq(ha[i], hb[j]);
        end
      end
      for (int r = 0; r < 3; r++) begin
        h1_t_q[r] <= sq_c_q[S][7+r];
      end
      h1_m_q   <= sq_m_q[S];
      h1_ctx_q <= sq_ctx_q[S];

      h2_q_q   <= hq_d;
      h2_t_q   <= h1_t_q;
      h2_m_q   <= h1_m_q;
      h2_ctx_q <= h1_ctx_q;

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          r1_p_q[i][j] <= rpe_pkg::mq(h2_q_q[i], h2_m_q[j]);
        end
      end
      r1_q_q   <= h2_q_q;
      r1_t_q   <= h2_t_q;
      r1_ctx_q <= h2_ctx_q;

      r2_v_q   <= rv_d;
      r2_q_q   <= r1_q_q;
      r2_t_q   <= r1_t_q;
      r2_ctx_q <= r1_ctx_q;

      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 4; j++) begin
          r3_p_q[r][j] <= rpe_pkg::mq(r3_a[r][j], r3_b[r][j]);
        end
      end
      r3_t_q   <= r2_t_q;
      r3_ctx_q <= r2_ctx_q;

      r4_x_q   <= xyz_d[0];
      r4_y_q   <= xyz_d[1];
      r4_z_q   <= xyz_d[2];
      r4_ctx_q <= r3_ctx_q;

      p1_fx_q  <= rpe_pkg::mq(focal_q, r4_x_q);
      p1_sy_q  <= rpe_pkg::mq(skew_q, r4_y_q);
      p1_pxz_q <= rpe_pkg::mq(prin_x_q, r4_z_q);
      p1_fay_q <= rpe_pkg::mq(fa_q, r4_y_q);
      p1_pyz_q <= rpe_pkg::mq(prin_y_q, r4_z_q);
      p1_z_q   <= r4_z_q;
      p1_ctx_q <= p1_ctx_d;

      p2_nx_q  <= rpe_pkg::sat32(rpe_pkg::sum_t'(p1_fx_q) + rpe_pkg::sum_t'(p1_sy_q)
                                 + rpe_pkg::sum_t'(p1_pxz_q));
      p2_ny_q  <= rpe_pkg::sat32(rpe_pkg::sum_t'(p1_fay_q) + rpe_pkg::sum_t'(p1_pyz_q));
      p2_z_q   <= p1_z_q;
      p2_ctx_q <= p1_ctx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // perspective divide
  // ---------------------------------------------------------------------------
  logic          dv_vld;
  rpe_pkg::q_t   dv_x, dv_y;
  rpe_pkg::ctx_t dv_ctx;

  rpe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p2_vld_q),
    .num_x_i (p2_nx_q),
    .num_y_i (p2_ny_q),
    .den_i   (p2_z_q),
    .ctx_i   (p2_ctx_q),
    .valid_o (dv_vld),
    .quo_x_o (dv_x),
    .quo_y_o (dv_y),
    .ctx_o   (dv_ctx)
  );

  // ---------------------------------------------------------------------------
  // error and output register
  // ---------------------------------------------------------------------------
  rpe_pkg::q_t                 out_ex_q, out_ey_q;
  logic [rpe_pkg::STATUS_W-1:0] out_st_q;
  logic                        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_ctx.status == rpe_pkg::ST_ZERO_DEPTH) begin
        out_ex_q <= rpe_pkg::Q_MAX;
        out_ey_q <= rpe_pkg::Q_MAX;
      end else begin
        out_ex_q <= rpe_pkg::sat32(rpe_pkg::sum_t'(dv_ctx.meas_x) - rpe_pkg::sum_t'(dv_x));
        out_ey_q <= rpe_pkg::sat32(rpe_pkg::sum_t'(dv_ctx.meas_y) - rpe_pkg::sum_t'(dv_y));
      end
      out_st_q   <= dv_ctx.status;
      out_last_q <= dv_ctx.last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_ey_q, out_ex_q};
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ tb/reprojection_error_checker.sv @@
// checker for the reprojection error unit: tracks tables and intrinsics, predicts and compares
`default_nettype none

module reprojection_error_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_i,
  input  logic [rpe_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic [rpe_pkg::ACT_W-1:0]          s_axis_tuser_i,
  input  logic                               s_axis_tlast_i,
  input  logic                               m_axis_tvalid_i,
  input  logic                               m_axis_tready_i,
  input  logic [rpe_pkg::OUT_DATA_W-1:0]     m_axis_tdata_i,
  input  logic [rpe_pkg::STATUS_W-1:0]       m_axis_tuser_i,
  input  logic                               m_axis_tlast_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [rpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rpe_pkg::Q_W-1:0]            cfg_data_i,
  output int                                 pending_o,
  output int                                 errors_o
);
  import rpe_pkg::*;

  typedef struct {
    logic [31:0]         err_x;
    logic [31:0]         err_y;
    logic [STATUS_W-1:0] status;
    logic                last;
  } pixel_err_t;

  pixel_err_t err_fifo[$];
  longint cam_tbl[CAM_WORDS*MAX_CAMERAS_DEF];
  longint pt_tbl[PT_WORDS*MAX_POINTS_DEF];
  longint focal, prin_x, prin_y, aspect, skew_c;
  int     n_err;
  int     n_pend;

  function automatic longint mul_q(longint a, longint b);
    longint p;
    p = a * b;
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_q(longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 40;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // full projection of one observation against the current tables
  function automatic pixel_err_t project_error(logic [5:0] ci, logic [9:0] pi,
                                               longint meas_x, longint meas_y, logic last);
    longint c[CAM_WORDS];
    longint m[PT_WORDS];
    longint arg, w, q0, q1, q2, q3, s, xr, yr, zr, px, py, pz, nx, ny, fa;
    pixel_err_t r;
    for (int k = 0; k < CAM_WORDS; k++) c[k] = cam_tbl[ci*CAM_WORDS + k];
    for (int k = 0; k < PT_WORDS; k++) m[k] = pt_tbl[pi*PT_WORDS + k];
    r.status = ST_OK;
    r.last   = last;
    arg = 65536 - (mul_q(c[4], c[4]) + mul_q(c[5], c[5]) + mul_q(c[6], c[6]));
    if (arg < 0) begin
      w = 0;
      r.status = ST_NEG_ROOT;
    end else begin
      w = root_q(arg <<< 16);
    end
    // incremental quaternion times the initial one
    q0 = clamp32(mul_q(w, c[0]) - mul_q(c[4], c[1]) - mul_q(c[5], c[2]) - mul_q(c[6], c[3]));
    q1 = clamp32(mul_q(w, c[1]) + mul_q(c[4], c[0]) + mul_q(c[5], c[3]) - mul_q(c[6], c[2]));
    q2 = clamp32(mul_q(w, c[2]) - mul_q(c[4], c[3]) + mul_q(c[5], c[0]) + mul_q(c[6], c[1]));
    q3 = clamp32(mul_q(w, c[3]) + mul_q(c[4], c[2]) - mul_q(c[5], c[1]) + mul_q(c[6], c[0]));
    s  = clamp32(-mul_q(q1, m[0]) - mul_q(q2, m[1]) - mul_q(q3, m[2]));
    xr = clamp32(mul_q(q0, m[0]) + mul_q(q2, m[2]) - mul_q(q3, m[1]));
    yr = clamp32(mul_q(q0, m[1]) + mul_q(q3, m[0]) - mul_q(q1, m[2]));
    zr = clamp32(mul_q(q0, m[2]) + mul_q(q1, m[1]) - mul_q(q2, m[0]));
    px = clamp32(-mul_q(q1, s) + mul_q(q0, xr) - mul_q(q3, yr) + mul_q(q2, zr) + c[7]);
    py = clamp32(-mul_q(q2, s) + mul_q(q0, yr) - mul_q(q1, zr) + mul_q(q3, xr) + c[8]);
    pz = clamp32(-mul_q(q3, s) + mul_q(q0, zr) - mul_q(q2, xr) + mul_q(q1, yr) + c[9]);
    if (pz == 0) begin
      r.err_x  = 32'h7FFF_FFFF;
      r.err_y  = 32'h7FFF_FFFF;
      r.status = ST_ZERO_DEPTH;
    end else begin
      nx = clamp32(mul_q(focal, px) + mul_q(skew_c, py) + mul_q(prin_x, pz));
      fa = clamp32(mul_q(focal, aspect));
      ny = clamp32(mul_q(fa, py) + mul_q(prin_y, pz));
      r.err_x = 32'(clamp32(meas_x - clamp32((nx * 65536) / pz)));
      r.err_y = 32'(clamp32(meas_y - clamp32((ny * 65536) / pz)));
    end
    return r;
  endfunction

  assign pending_o = n_pend;
  assign errors_o  = n_err;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [5:0]  ci;
    logic [9:0]  pi;
    logic [3:0]  ws;
    longint      lv, mx, my;
    pixel_err_t  exp_r;
    if (!rst_ni) begin
      focal  = 65536;
      prin_x = 0;
      prin_y = 0;
      aspect = 65536;
      skew_c = 0;
      n_err  = 0;
      err_fifo.delete();
      n_pend = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FOCAL:  focal  = longint'($signed(cfg_data_i));
          CFG_PRIN_X: prin_x = longint'($signed(cfg_data_i));
          CFG_PRIN_Y: prin_y = longint'($signed(cfg_data_i));
          CFG_ASPECT: aspect = longint'($signed(cfg_data_i));
          CFG_SKEW:   skew_c = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        ci = s_axis_tdata_i[5:0];
        pi = s_axis_tdata_i[15:6];
        ws = s_axis_tdata_i[19:16];
        lv = longint'($signed(s_axis_tdata_i[51:20]));
        mx = longint'($signed(s_axis_tdata_i[83:52]));
        my = longint'($signed(s_axis_tdata_i[115:84]));
        case (s_axis_tuser_i)
          ACT_LOAD_CAM: if (ws < CAM_WORDS) cam_tbl[ci*CAM_WORDS + ws] = lv;
          ACT_LOAD_PT:  if (ws < PT_WORDS) pt_tbl[pi*PT_WORDS + ws] = lv;
          ACT_PROJECT:  err_fifo.push_back(project_error(ci, pi, mx, my, s_axis_tlast_i));
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (err_fifo.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result word: x=%h y=%h st=%0d last=%b",
                     m_axis_tdata_i[31:0], m_axis_tdata_i[63:32], m_axis_tuser_i,
                     m_axis_tlast_i);
        end else begin
          exp_r = err_fifo.pop_front();
          if (exp_r.err_x !== m_axis_tdata_i[31:0] || exp_r.err_y !== m_axis_tdata_i[63:32] ||
              exp_r.status !== m_axis_tuser_i || exp_r.last !== m_axis_tlast_i) begin
            n_err++;
            if (n_err <= 10)
              $display({"result mismatch: exp x=%h y=%h st=%0d last=%b, ",
                        "got x=%h y=%h st=%0d last=%b"},
                       exp_r.err_x, exp_r.err_y, exp_r.status, exp_r.last,
                       m_axis_tdata_i[31:0], m_axis_tdata_i[63:32], m_axis_tuser_i,
                       m_axis_tlast_i);
          end
        end
      end
      n_pend = err_fifo.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/reprojection_error_unit_tb.sv @@
// testbench top for the reprojection error unit: clock, reset, stimulus and verdict
`default_nettype none

module reprojection_error_unit_tb;
  import rpe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 120;   // comfortably past the pipeline depth

  // codes that the unit must ignore
  localparam logic [ACT_W-1:0]     ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [ACT_W-1:0]        s_tuser = '0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]     m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [Q_W-1:0]          cfg_data = '0;
  int                      pending, mismatches;

  // stimulus shaping
  bit       no_idle = 1'b0;
  int       hold_tickets = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       cycles = 0;

  // which table words have been written, and the fully loaded entries
  logic [CAM_WORDS-1:0] cam_mask[MAX_CAMERAS_DEF];
  logic [PT_WORDS-1:0]  pt_mask[MAX_POINTS_DEF];
  int                   full_cams[$];
  int                   full_pts[$];

  always #5 clk_i = ~clk_i;

  reprojection_error_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  reprojection_error_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .errors_o        (mismatches)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random backpressure, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_tickets) begin
      hold_seen <= hold_tickets;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 34);
    end
  end

  function automatic logic [31:0] srand(int unsigned span);
    return 32'($signed({1'b0, $urandom_range(0, 2*span)}) - $signed({1'b0, span}));
  endfunction

  // plausible table contents so most projections stay in range
  function automatic logic [31:0] plausible(logic [ACT_W-1:0] act, int ws);
    if (act == ACT_LOAD_PT) return (ws == 2) ? srand(5*65536) : srand(10*65536);
    case (ws)
      0:       return 32'(65536 - $urandom_range(0, 8192));
      1, 2, 3: return srand(16384);
      4, 5, 6: return srand(20000);
      7, 8:    return srand(5*65536);
      default: return 32'($urandom_range(3*65536, 20*65536));
    endcase
  endfunction

  task automatic send_word(logic [ACT_W-1:0] act, logic [5:0] ci, logic [9:0] pi,
                           logic [3:0] ws, logic [31:0] lv, logic [31:0] mx,
                           logic [31:0] my, logic last);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= {4'b0, my, mx, lv, ws, pi, ci};
    s_tuser  <= act;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    // keep track of fully loaded entries so projections never touch unwritten words
    if (act == ACT_LOAD_CAM && ws < CAM_WORDS && !(&cam_mask[ci])) begin
      cam_mask[ci][ws] = 1'b1;
      if (&cam_mask[ci]) full_cams.push_back(ci);
    end
    if (act == ACT_LOAD_PT && ws < PT_WORDS && !(&pt_mask[pi])) begin
      pt_mask[pi][ws] = 1'b1;
      if (&pt_mask[pi]) full_pts.push_back(pi);
    end
  endtask

  task automatic load_camera(int ci, logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                             logic [31:0] w3, logic [31:0] w4, logic [31:0] w5,
                             logic [31:0] w6, logic [31:0] w7, logic [31:0] w8,
                             logic [31:0] w9);
    logic [31:0] w[CAM_WORDS];
    w = '{w0, w1, w2, w3, w4, w5, w6, w7, w8, w9};
    for (int k = 0; k < CAM_WORDS; k++)
      send_word(ACT_LOAD_CAM, 6'(ci), 10'($urandom), 4'(k), w[k], $urandom, $urandom,
                1'($urandom));
  endtask

  task automatic load_point(int pi, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(ACT_LOAD_PT, 6'($urandom), 10'(pi), 4'd0, x, $urandom, $urandom, 1'b0);
    send_word(ACT_LOAD_PT, 6'($urandom), 10'(pi), 4'd1, y, $urandom, $urandom, 1'b1);
    send_word(ACT_LOAD_PT, 6'($urandom), 10'(pi), 4'd2, z, $urandom, $urandom, 1'b0);
  endtask

  task automatic project(int ci, int pi, logic [31:0] mx, logic [31:0] my, logic last);
    send_word(ACT_PROJECT, 6'(ci), 10'(pi), 4'($urandom), $urandom, mx, my, last);
  endtask

  // let every outstanding result come back, then give the pipeline time to empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_intrinsics(logic [31:0] f, logic [31:0] px, logic [31:0] py,
                                  logic [31:0] ar, logic [31:0] sk);
    write_reg(CFG_FOCAL, f);
    write_reg(CFG_PRIN_X, px);
    write_reg(CFG_PRIN_Y, py);
    write_reg(CFG_ASPECT, ar);
    write_reg(CFG_SKEW, sk);
    // an out-of-range index must be ignored
    write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic random_words(int count);
    int          r, ws;
    logic [ACT_W-1:0] act;
    logic [31:0] val;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55 && full_cams.size() > 0 && full_pts.size() > 0) begin
        project(full_cams[$urandom_range(0, full_cams.size()-1)],
                full_pts[$urandom_range(0, full_pts.size()-1)],
                $urandom, $urandom, 1'($urandom));
      end else if (r < 90) begin
        act = $urandom_range(0, 1) ? ACT_LOAD_CAM : ACT_LOAD_PT;
        ws  = (act == ACT_LOAD_CAM) ? $urandom_range(0, CAM_WORDS-1)
                                    : $urandom_range(0, PT_WORDS-1);
        val = ($urandom_range(0, 3) == 0) ? $urandom : plausible(act, ws);
        send_word(act, 6'($urandom), 10'($urandom), 4'(ws), val, $urandom, $urandom,
                  1'($urandom));
      end else begin
        // ignored words: unused action or a word select past the entry
        case ($urandom_range(0, 2))
          0: send_word(ACT_UNUSED, 6'($urandom), 10'($urandom), 4'($urandom), $urandom,
                       $urandom, $urandom, 1'($urandom));
          1: send_word(ACT_LOAD_CAM, 6'($urandom), 10'($urandom),
                       4'($urandom_range(CAM_WORDS, 15)), $urandom, $urandom, $urandom,
                       1'($urandom));
          default: send_word(ACT_LOAD_PT, 6'($urandom), 10'($urandom),
                             4'($urandom_range(PT_WORDS, 15)), $urandom, $urandom,
                             $urandom, 1'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    for (int k = 0; k < MAX_CAMERAS_DEF; k++) cam_mask[k] = '0;
    for (int k = 0; k < MAX_POINTS_DEF; k++) pt_mask[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity camera, negative root argument, zero depth, extreme words
    load_camera(0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0005_0000);
    load_camera(1, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0,
                32'h0004_0000);
    load_camera(2, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    load_camera(63, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    load_point(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    load_point(1, 32'h0001_0000, 32'hFFFF_0000, 0);
    load_point(1023, Q_MAX, Q_MIN, Q_MAX);
    project(0, 0, Q_MAX, Q_MIN, 1'b1);
    project(0, 0, Q_MIN, Q_MAX, 1'b0);
    project(1, 0, 0, 0, 1'b0);
    project(2, 1, 32'h1234_5678, 32'h8765_4321, 1'b1);
    project(63, 1023, 0, 0, 1'b0);
    project(0, 1023, 32'hFFFF_FFFF, 0, 1'b1);
    send_word(ACT_UNUSED, 6'h3F, 10'h3FF, 4'hF, Q_MAX, Q_MAX, Q_MAX, 1'b1);
    send_word(ACT_LOAD_CAM, 6'd0, 10'd0, 4'hF, Q_MIN, 0, 0, 1'b0);
    send_word(ACT_LOAD_PT, 6'd0, 10'd0, 4'd3, Q_MIN, 0, 0, 1'b0);
    project(0, 0, 0, 0, 1'b0);

    random_words(300);
    drain();

    // typical intrinsics, then a long result-side hold-off with the sender flat out
    write_intrinsics(32'(500 * 65536), 32'(320 * 65536), 32'(240 * 65536), 32'h0001_0000,
                     32'h0000_0800);
    no_idle = 1'b1;
    hold_tickets++;
    random_words(250);
    no_idle = 1'b0;
    random_words(100);
    drain();

    write_intrinsics(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    random_words(220);
    drain();

    write_intrinsics(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    random_words(220);
    drain();

    write_intrinsics(0, 0, 0, 0, 0);
    random_words(120);
    drain();

    write_intrinsics($urandom, $urandom, $urandom, $urandom, $urandom);
    random_words(150);
    // sender pauses until every result is back, then carries on
    drain();
    random_words(150);
    drain();

    write_intrinsics(32'(800 * 65536), srand(400 * 65536), srand(400 * 65536),
                     32'($urandom_range(32768, 131072)), srand(65536));
    no_idle = 1'b1;
    random_words(100);
    no_idle = 1'b0;
    random_words(100);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
